### rtl/core/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types and constants of the set-associative write-back cache.
// ----------------------------------------------------------------------------
package sca_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_WAYS_USED   = 2'd0;
  localparam logic [1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // reset values of the configuration registers
  localparam logic [3:0] WAYS_USED_RST   = 4'd8;
  localparam logic [3:0] SET_BITS_RST    = 4'd8;
  localparam logic [2:0] OFFSET_BITS_RST = 3'd5;

  // access kind
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  typedef struct packed {
    logic        done_res;
    logic        hit;
    logic        writeback_valid;
    logic [31:0] writeback_address;
    logic        fetch_valid;
    logic [31:0] fetch_address;
  } result_t;

endpackage

### rtl/core/sca_req_if.sv
// ----------------------------------------------------------------------------
// sca_req_if
// Access request channel: kind and byte address with valid/ready.
// ----------------------------------------------------------------------------
interface sca_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink (input valid, input kind, input address, output ready);
endinterface

### rtl/core/sca_rsp_if.sv
// ----------------------------------------------------------------------------
// sca_rsp_if
// Access result channel: hit, writeback and fetch reports with valid/ready.
// ----------------------------------------------------------------------------
interface sca_rsp_if;
  logic        valid;
  logic        ready;
  logic        done_res;
  logic        hit;
  logic        writeback_valid;
  logic [31:0] writeback_address;
  logic        fetch_valid;
  logic [31:0] fetch_address;

  modport source (output valid, output done_res, output hit, output writeback_valid,
                  output writeback_address, output fetch_valid, output fetch_address,
                  input ready);
  modport sink (input valid, input done_res, input hit, input writeback_valid,
                input writeback_address, input fetch_valid, input fetch_address,
                output ready);
endinterface

### rtl/core/sca_set_ram.sv
// ----------------------------------------------------------------------------
// sca_set_ram
// One row per set: tags, valid, dirty and ranks of all ways. Registered read.
// ----------------------------------------------------------------------------
module sca_set_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned ROW_W  = 64
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [ROW_W-1:0]  rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [ROW_W-1:0]  wr_data_i
);

  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [ROW_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/sca_lookup.sv
// ----------------------------------------------------------------------------
// sca_lookup
// Tag compare, victim choice and true-LRU rank update of one set row.
// ----------------------------------------------------------------------------
module sca_lookup #(
  parameter int unsigned WAYS   = 8,
  parameter int unsigned ADDR_W = 32,
  parameter int unsigned RANK_W = 3,
  parameter int unsigned SIDX_W = 8,
  parameter int unsigned ROW_W  = WAYS * (ADDR_W + 2 + RANK_W)
) (
  input  logic [ROW_W-1:0]  row_i,
  input  logic              kind_i,
  input  logic [31:0]       addr_i,
  input  logic [ADDR_W-1:0] tag_i,
  input  logic [SIDX_W-1:0] set_i,
  input  logic [4:0]        nw_i,
  input  logic [2:0]        ob_i,
  input  logic [4:0]        sh_i,
  output logic [ROW_W-1:0]  row_o,
  output sca_pkg::result_t  res_o
);

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [31:0] AMASK = (ADDR_W >= 32) ? 32'hFFFF_FFFF
                                                 : ((32'd1 << ADDR_W) - 32'd1);

  logic [ADDR_W-1:0] tag   [WAYS];
  logic [RANK_W-1:0] rank  [WAYS];
  logic [WAYS-1:0]   valid;
  logic [WAYS-1:0]   dirty;
  logic [ADDR_W-1:0] tag_n [WAYS];
  logic [RANK_W-1:0] rank_n[WAYS];
  logic [WAYS-1:0]   valid_n;
  logic [WAYS-1:0]   dirty_n;
  logic [WAYS-1:0]   in_use;

  logic             hit;
  logic             found;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] lru_way;
  logic [WAY_W-1:0] way;
  logic [RANK_W-1:0] old_rank;
  logic             age_all;
  logic [31:0]      victim_tag;

  // unpack the row
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      tag[i]    = row_i[i*ADDR_W +: ADDR_W];
      rank[i]   = row_i[WAYS*(ADDR_W+2) + i*RANK_W +: RANK_W];
      valid[i]  = row_i[WAYS*ADDR_W + i];
      dirty[i]  = row_i[WAYS*(ADDR_W+1) + i];
      in_use[i] = (5'(i) < nw_i);
    end
  end

  // hit search and first free way, lowest way wins
  always_comb begin
    hit      = 1'b0;
    found    = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (in_use[i] && valid[i] && (tag[i] == tag_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (in_use[i] && !valid[i]) begin
        found    = 1'b1;
        free_way = WAY_W'(i);
      end
    end
  end

  // lru victim: first way of highest rank
  always_comb begin
    lru_way = '0;
    for (int i = 1; i < WAYS; i++) begin
      if (in_use[i] && (rank[i] > rank[lru_way])) begin
        lru_way = WAY_W'(i);
      end
    end
  end

  assign way      = hit ? hit_way : (found ? free_way : lru_way);
  assign age_all  = !hit && found;
  assign old_rank = rank[way];

  // rank update and line fill
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      tag_n[i]   = tag[i];
      rank_n[i]  = rank[i];
      valid_n[i] = valid[i];
      dirty_n[i] = dirty[i];
      if (WAY_W'(i) == way) begin
        rank_n[i] = '0;
        if (hit) begin
          dirty_n[i] = dirty[i] | (kind_i == sca_pkg::KIND_WRITE);
        end else begin
          tag_n[i]   = tag_i;
          valid_n[i] = 1'b1;
          dirty_n[i] = kind_i;
        end
      end else if (in_use[i] && valid[i] && (age_all || (rank[i] < old_rank))) begin
        rank_n[i] = rank[i] + RANK_W'(1);
      end
    end
  end

  // repack the row
  always_comb begin
    row_o = '0;
    for (int i = 0; i < WAYS; i++) begin
      row_o[i*ADDR_W +: ADDR_W]                     = tag_n[i];
      row_o[WAYS*ADDR_W + i]                        = valid_n[i];
      row_o[WAYS*(ADDR_W+1) + i]                    = dirty_n[i];
      row_o[WAYS*(ADDR_W+2) + i*RANK_W +: RANK_W]   = rank_n[i];
    end
  end

  // result
  assign victim_tag = 32'(tag[lru_way]);

  always_comb begin
    res_o                   = '0;
    res_o.done_res          = 1'b1;
    res_o.hit               = hit;
    res_o.fetch_valid       = !hit;
    res_o.writeback_valid   = !hit && !found && dirty[lru_way];
    if (res_o.writeback_valid) begin
      res_o.writeback_address = ((victim_tag << sh_i) | (32'(set_i) << ob_i)) & AMASK;
    end
    if (!hit) begin
      res_o.fetch_address = (addr_i >> ob_i) << ob_i;
    end
  end

endmodule

### rtl/core/set_assoc_lru_writeback_cache.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache
// Set-associative write-back, write-allocate cache directory with true LRU.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    kind, address
//  rsp_o    out  valid/ready    done_res, hit, writeback_*, fetch_*
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
//  each request reads one set row when it is accepted, then compares, updates and
//  writes back that row through the set memory.
//  after reset a clearing pass writes all SETS rows, one per cycle, before
//  the first request is taken.
//  a finished result waits in the output register; the next request may be
//  accepted meanwhile, and is held in the update cycle until that slot frees.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache #(
  parameter int unsigned SETS   = 256,
  parameter int unsigned WAYS   = 8,
  parameter int unsigned ADDR_W = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sca_req_if.sink                           req_i,
  sca_rsp_if.source                         rsp_o,
  input  logic                              cfg_we_i,
  input  logic [sca_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sca_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned SIDX_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned SB_MAX  = $clog2(SETS + 1) - 1;
  localparam int unsigned RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W   = WAYS * (ADDR_W + 2 + RANK_W);
  localparam logic [31:0] AMASK   = (ADDR_W >= 32) ? 32'hFFFF_FFFF
                                                   : ((32'd1 << ADDR_W) - 32'd1);

  sca_pkg::state_e   state_q, state_d;
  logic [SIDX_W-1:0] clr_q, clr_d;
  logic [3:0]        ways_used_q;
  logic [3:0]        set_bits_q;
  logic [2:0]        offset_bits_q;
  logic              kind_q;
  logic [31:0]       addr_q;
  logic              out_valid_q, out_valid_d;
  sca_pkg::result_t  out_q;

  logic [4:0]        nw;
  logic [3:0]        sb;
  logic [4:0]        sh;
  logic [31:0]       req_addr;
  logic [SIDX_W-1:0] req_set;
  logic [SIDX_W-1:0] cur_set;
  logic [ADDR_W-1:0] cur_tag;
  logic [31:0]       set_mask;
  logic              accept;
  logic              load_out;
  logic              rd_en;
  logic              wr_en;
  logic [SIDX_W-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  upd_row;
  sca_pkg::result_t  res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_used_q   <= sca_pkg::WAYS_USED_RST;
      set_bits_q    <= sca_pkg::SET_BITS_RST;
      offset_bits_q <= sca_pkg::OFFSET_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sca_pkg::CFG_WAYS_USED:   ways_used_q   <= cfg_wdata_i;
        sca_pkg::CFG_SET_BITS:    set_bits_q    <= cfg_wdata_i;
        sca_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    if (ways_used_q == 4'd0) begin
      nw = 5'd1;
    end else if (5'(ways_used_q) > 5'(WAYS)) begin
      nw = 5'(WAYS);
    end else begin
      nw = 5'(ways_used_q);
    end
    sb       = (32'(set_bits_q) > SB_MAX) ? 4'(SB_MAX) : set_bits_q;
    sh       = 5'(offset_bits_q) + 5'(sb);
    set_mask = (32'd1 << sb) - 32'd1;
  end

  // set index and tag
  assign req_addr = req_i.address & AMASK;
  assign req_set  = SIDX_W'((req_addr >> offset_bits_q) & set_mask);
  assign cur_set  = SIDX_W'((addr_q >> offset_bits_q) & set_mask);
  assign cur_tag  = ADDR_W'(addr_q >> sh);

  assign req_i.ready = (state_q == sca_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign load_out    = (state_q == sca_pkg::ST_LOOK) && (!out_valid_q || rsp_o.ready);

  // control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cur_set;
    wr_data     = upd_row;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      sca_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + SIDX_W'(1);
        if (clr_q == SIDX_W'(SETS - 1)) begin
          state_d = sca_pkg::ST_IDLE;
        end
      end
      sca_pkg::ST_IDLE: begin
        if (accept) begin
          rd_en   = 1'b1;
          state_d = sca_pkg::ST_LOOK;
        end
      end
      sca_pkg::ST_LOOK: begin
        if (load_out) begin
          wr_en       = 1'b1;
          out_valid_d = 1'b1;
          state_d     = sca_pkg::ST_IDLE;
        end
      end
      default: state_d = sca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sca_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req_i.kind;
      addr_q <= req_addr;
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  sca_set_ram #(
    .DEPTH  (SETS),
    .ADDR_W (SIDX_W),
    .ROW_W  (ROW_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (req_set),
    .rd_data_o (rd_row),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  sca_lookup #(
    .WAYS   (WAYS),
    .ADDR_W (ADDR_W),
    .RANK_W (RANK_W),
    .SIDX_W (SIDX_W),
    .ROW_W  (ROW_W)
  ) u_lookup (
    .row_i  (rd_row),
    .kind_i (kind_q),
    .addr_i (addr_q),
    .tag_i  (cur_tag),
    .set_i  (cur_set),
    .nw_i   (nw),
    .ob_i   (offset_bits_q),
    .sh_i   (sh),
    .row_o  (upd_row),
    .res_o  (res)
  );

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.done_res          = out_q.done_res;
  assign rsp_o.hit               = out_q.hit;
  assign rsp_o.writeback_valid   = out_q.writeback_valid;
  assign rsp_o.writeback_address = out_q.writeback_address;
  assign rsp_o.fetch_valid       = out_q.fetch_valid;
  assign rsp_o.fetch_address     = out_q.fetch_address;

endmodule
